/* src/ttrrs_pkg.sv */
// shared types, codes and sizes for the task table round-robin scheduler
`default_nettype none

package ttrrs_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int PADDR_W       = 4;
  localparam int DATA_W        = 32;

  typedef logic [2:0]        task_id_t;
  typedef logic [2:0]        action_t;
  typedef logic [1:0]        status_t;
  typedef logic [1:0]        slot_st_t;
  typedef logic [1:0]        reg_idx_t;
  typedef logic [DATA_W-1:0] addr_t;

  localparam slot_st_t ST_FREE    = 2'd0;
  localparam slot_st_t ST_READY   = 2'd1;
  localparam slot_st_t ST_RUNNING = 2'd2;
  localparam slot_st_t ST_BLOCKED = 2'd3;

  localparam action_t ACT_CREATE  = 3'd0;
  localparam action_t ACT_STOP    = 3'd1;
  localparam action_t ACT_BLOCK   = 3'd2;
  localparam action_t ACT_UNBLOCK = 3'd3;
  localparam action_t ACT_SCHED   = 3'd4;

  localparam status_t STS_OK       = 2'd0;
  localparam status_t STS_NO_FREE  = 2'd1;
  localparam status_t STS_TGT_FREE = 2'd2;
  localparam status_t STS_IDLE     = 2'd3;

  localparam reg_idx_t REG_KSTACK = 2'd0;
  localparam reg_idx_t REG_TMEM   = 2'd1;
  localparam reg_idx_t REG_PGD    = 2'd2;

  typedef struct packed {
    task_id_t parent;
    slot_st_t st;
  } slot_ent_t;

endpackage

`default_nettype wire

/* src/ttrrs_if.sv */
// request and response channel interfaces of the scheduler
`default_nettype none

interface ttrrs_req_if;
  logic                 valid;
  logic                 ready;
  ttrrs_pkg::action_t   action;
  ttrrs_pkg::task_id_t  parent_id;
  ttrrs_pkg::task_id_t  target_id;

  modport source (output valid, output action, output parent_id, output target_id,
                  input ready);
  modport sink (input valid, input action, input parent_id, input target_id,
                output ready);
endinterface

interface ttrrs_rsp_if;
  logic                 valid;
  logic                 ready;
  ttrrs_pkg::status_t   status;
  ttrrs_pkg::task_id_t  new_id;
  ttrrs_pkg::addr_t     new_stack_top;
  ttrrs_pkg::addr_t     page_dir_addr;
  ttrrs_pkg::task_id_t  running_id;
  logic                 switched;

  modport source (output valid, output status, output new_id, output new_stack_top,
                  output page_dir_addr, output running_id, output switched,
                  input ready);
  modport sink (input valid, input status, input new_id, input new_stack_top,
                input page_dir_addr, input running_id, input switched,
                output ready);
endinterface

`default_nettype wire

/* src/task_table_round_robin_scheduler.sv */
// task table round-robin scheduler: slot table memory, scan sequencer, apb registers
// an unblock of an id outside the table skips the table read
// throughput: one request at a time, the scan reads one table entry per cycle
// reset: slot 0 running, all other slots free (per-slot valid bits, no clearing pass),
// current task 0, registers zero
`default_nettype none

module task_table_round_robin_scheduler #(
  parameter int NUM_TASKS = ttrrs_pkg::NUM_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttrrs_pkg::PADDR_W-1:0] paddr,
  input  logic [ttrrs_pkg::DATA_W-1:0]  pwdata,
  output logic [ttrrs_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  ttrrs_req_if.sink                     req,
  ttrrs_rsp_if.source                   rsp
);
  import ttrrs_pkg::*;

  localparam int              ID_W    = $clog2(NUM_TASKS);
  localparam logic [ID_W-1:0] LAST_ID = ID_W'(NUM_TASKS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_CUR  = 3'd1;
  localparam logic [2:0] S_WR_CUR  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_UNB_RD  = 3'd4;
  localparam logic [2:0] S_UNB_CHK = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  // configuration registers
  addr_t kstack;
  addr_t tmem;
  addr_t pgdb;

  // sequencer
  logic [2:0]      fsm;
  action_t         act;
  task_id_t        par;
  task_id_t        tgt;
  logic [ID_W-1:0] cur;
  logic [ID_W-1:0] prev_cur;
  logic [ID_W-1:0] rd_idx;
  logic [ID_W-1:0] scan_cnt;
  logic            chk;
  logic            tgt_oob;

  // pending result
  status_t  r_status;
  task_id_t r_new_id;
  addr_t    r_stack;
  addr_t    r_pgd;

  // output register
  logic     out_valid;
  status_t  o_status;
  task_id_t o_new_id;
  addr_t    o_stack;
  addr_t    o_pgd;
  task_id_t o_running;
  logic     o_switched;

  // slot table
  slot_ent_t       mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] slot_vld;
  slot_ent_t       mem_q;
  logic            rd_vld_q;
  logic [ID_W-1:0] rd_addr;
  logic [ID_W-1:0] rd_addr_q;
  slot_ent_t       rd_ent;
  logic            mem_we;
  logic [ID_W-1:0] mem_wa;
  slot_ent_t       mem_wd;
  logic            is_create;
  logic            hit;
  addr_t           stack_of;
  addr_t           pgd_of;

  function automatic logic [ID_W-1:0] inc_id(input logic [ID_W-1:0] i);
    return (i == LAST_ID) ? '0 : i + 1'b1;
  endfunction

  // apb port
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[PADDR_W-1:2]))
      REG_KSTACK: prdata = kstack;
      REG_TMEM:   prdata = tmem;
      REG_PGD:    prdata = pgdb;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kstack <= '0;
      tmem   <= '0;
      pgdb   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[PADDR_W-1:2]))
        REG_KSTACK: kstack <= pwdata;
        REG_TMEM:   tmem   <= pwdata;
        REG_PGD:    pgdb   <= pwdata;
        default:    ;
      endcase
    end
  end

  // a slot never written reads as its reset value
  always_comb begin
    if (rd_vld_q) begin
      rd_ent = mem_q;
    end else begin
      rd_ent.parent = '0;
      rd_ent.st     = (rd_addr_q == '0) ? ST_RUNNING : ST_FREE;
    end
  end

  always_comb begin
    case (fsm)
      S_RD_CUR: rd_addr = cur;
      S_SCAN:   rd_addr = rd_idx;
      S_UNB_RD: rd_addr = ID_W'(tgt);
      default:  rd_addr = cur;
    endcase
  end

  assign is_create = (act == ACT_CREATE);
  assign hit       = is_create ? (rd_ent.st == ST_FREE) : (rd_ent.st == ST_READY);
  assign stack_of  = (rd_addr_q == '0) ? kstack : tmem + (DATA_W'(rd_addr_q) << 22);
  assign pgd_of    = pgdb + (DATA_W'(rd_addr_q) << 12);
  assign tgt_oob   = (32'(req.target_id) >= 32'(NUM_TASKS));

  // read-modify-write of the entry returned by the previous read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr_q;
    mem_wd = rd_ent;
    case (fsm)
      S_WR_CUR: begin
        mem_we = 1'b1;
        case (act)
          ACT_STOP: mem_wd.st = ST_FREE;
          ACT_BLOCK: begin
            if (rd_ent.st != ST_FREE) mem_wd.st = ST_BLOCKED;
          end
          default: begin
            if (rd_ent.st == ST_RUNNING) mem_wd.st = ST_READY;
          end
        endcase
      end
      S_SCAN: begin
        mem_we = chk && hit;
        if (is_create) begin
          mem_wd.parent = par;
          mem_wd.st     = ST_READY;
        end else begin
          mem_wd.st = ST_RUNNING;
        end
      end
      S_UNB_CHK: begin
        mem_we    = (rd_ent.st != ST_FREE) && (rd_ent.st != ST_RUNNING);
        mem_wd.st = ST_READY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q     <= mem[rd_addr];
    rd_vld_q  <= slot_vld[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (mem_we) begin
      slot_vld[mem_wa] <= 1'b1;
    end
  end

  assign req.ready = (fsm == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      cur       <= '0;
      chk       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in the done state the output register is reloaded instead of cleared
      if (rsp.valid && rsp.ready && fsm != S_DONE) out_valid <= 1'b0;
      case (fsm)
        S_IDLE: begin
          if (req.valid) begin
            act      <= req.action;
            par      <= req.parent_id;
            tgt      <= req.target_id;
            prev_cur <= cur;
            r_status <= (req.action == ACT_UNBLOCK && tgt_oob) ? STS_TGT_FREE : STS_OK;
            r_new_id <= '0;
            r_stack  <= '0;
            r_pgd    <= '0;
            case (req.action)
              ACT_CREATE: begin
                rd_idx   <= '0;
                scan_cnt <= '0;
                chk      <= 1'b0;
                fsm      <= S_SCAN;
              end
              ACT_STOP, ACT_BLOCK, ACT_SCHED: fsm <= S_RD_CUR;
              ACT_UNBLOCK: fsm <= tgt_oob ? S_DONE : S_UNB_RD;
              default: fsm <= S_DONE;
            endcase
          end
        end
        S_RD_CUR: fsm <= S_WR_CUR;
        S_WR_CUR: begin
          // ring scan starts after the current slot and ends on it
          rd_idx   <= inc_id(cur);
          scan_cnt <= '0;
          chk      <= 1'b0;
          fsm      <= S_SCAN;
        end
        S_SCAN: begin
          rd_idx <= inc_id(rd_idx);
          chk    <= 1'b1;
          if (chk) begin
            if (hit) begin
              if (is_create) begin
                r_new_id <= task_id_t'(rd_addr_q);
                r_stack  <= stack_of;
              end else begin
                cur <= rd_addr_q;
              end
              r_pgd <= pgd_of;
              fsm   <= S_DONE;
            end else if (scan_cnt == LAST_ID) begin
              r_status <= is_create ? STS_NO_FREE : STS_IDLE;
              fsm      <= S_DONE;
            end else begin
              scan_cnt <= scan_cnt + 1'b1;
            end
          end
        end
        S_UNB_RD: fsm <= S_UNB_CHK;
        S_UNB_CHK: begin
          if (rd_ent.st == ST_FREE) r_status <= STS_TGT_FREE;
          fsm <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            o_status   <= r_status;
            o_new_id   <= r_new_id;
            o_stack    <= r_stack;
            o_pgd      <= r_pgd;
            o_running  <= task_id_t'(cur);
            o_switched <= (cur != prev_cur);
            out_valid  <= 1'b1;
            fsm        <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = o_status;
  assign rsp.new_id        = o_new_id;
  assign rsp.new_stack_top = o_stack;
  assign rsp.page_dir_addr = o_pgd;
  assign rsp.running_id    = o_running;
  assign rsp.switched      = o_switched;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (fsm != S_IDLE))
    else $error("sequencer stayed idle after a request transfer");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (fsm != S_IDLE && fsm != S_DONE))
    else $error("slot table written outside an operation");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(fsm) == S_DONE))
    else $error("response raised without a finished operation");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.switched) |-> (rsp.status == STS_OK))
    else $error("task switch reported with a failing status");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_DONE) |-> (cur <= LAST_ID))
    else $error("current task outside the table");

endmodule

`default_nettype wire
